@@ src/fbik_pkg.sv @@
// Shared constants, types and the arctangent table for the five-bar leg IK pipeline.
// No dependencies; every other file in src uses it.
package fbik_pkg;

    localparam int COORD_W      = 16;   // target coordinate width
    localparam int ANGLE_FRAC   = 12;   // fraction bits of output angles
    localparam int ANGLE_OUT_W  = 16;   // output angle width
    localparam int LEN_W        = 15;   // link length register width
    localparam int CFG_IDX_W    = 4;
    localparam int CFG_DATA_W   = 16;
    localparam int Q_FRAC       = 30;   // internal angle fraction bits
    localparam int CORDIC_STEPS = 30;
    localparam int ISQRT_STEPS  = 31;   // result bits of the root
    localparam int VEC_W        = 36;   // CORDIC x/y width
    localparam int ANG_W        = 34;   // CORDIC z width
    localparam int SQ_W         = 32;   // square of a 16-bit magnitude
    localparam int LSQ_W        = 30;   // square of a 15-bit length
    localparam int D2_W         = 33;   // sum of two squares
    localparam int NAB_W        = 34;   // signed n, a, b
    localparam int NORM_W       = 31;   // normalized operand width
    localparam int PROD_W       = 62;
    localparam int ROOT_W       = 32;

    localparam logic [CFG_IDX_W-1:0] REG_UPPER = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_LOWER = CFG_IDX_W'(1);
    localparam logic [LEN_W-1:0]     LEN_RESET = LEN_W'(8192);

    localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 34'sd1686629713;

    // atan(2^-i) in Q4.30
    function automatic logic signed [ANG_W-1:0] atan_q30(input int i);
        case (i)
            0:  return 34'sd843314857;
            1:  return 34'sd497837829;
            2:  return 34'sd263043836;
            3:  return 34'sd133525158;
            4:  return 34'sd67021686;
            5:  return 34'sd33543515;
            6:  return 34'sd16775850;
            7:  return 34'sd8388437;
            8:  return 34'sd4194282;
            9:  return 34'sd2097149;
            10: return 34'sd1048575;
            11: return 34'sd524287;
            12: return 34'sd262143;
            13: return 34'sd131071;
            14: return 34'sd65535;
            15: return 34'sd32767;
            16: return 34'sd16383;
            17: return 34'sd8191;
            18: return 34'sd4095;
            19: return 34'sd2047;
            20: return 34'sd1023;
            21: return 34'sd511;
            22: return 34'sd255;
            23: return 34'sd127;
            24: return 34'sd63;
            25: return 34'sd31;
            26: return 34'sd15;
            27: return 34'sd8;
            28: return 34'sd4;
            29: return 34'sd2;
            default: return '0;
        endcase
    endfunction

    // front end result, one per pipeline slot
    typedef struct packed {
        logic                      vld;
        logic                      unr;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [NAB_W-1:0]   n;
        logic [PROD_W-1:0]         prod;
    } t_front;

    typedef struct packed {
        logic                    vld;
        logic                    unr;
        logic signed [NAB_W-1:0] n;
    } t_dly_a;

    typedef struct packed {
        logic                    vld;
        logic                    unr;
        logic signed [ANG_W-1:0] heading;
    } t_dly_b;

endpackage

@@ src/fbik_if.sv @@
// Handshake channel interfaces: target requests, results, configuration writes.
// Depends on fbik_pkg.
interface fbik_in_if;
    logic                               valid;
    logic                               ready;
    logic signed [fbik_pkg::COORD_W-1:0] target_x;
    logic signed [fbik_pkg::COORD_W-1:0] target_y;
    modport source (output valid, output target_x, output target_y, input ready);
    modport sink   (input valid, input target_x, input target_y, output ready);
endinterface

interface fbik_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [fbik_pkg::ANGLE_OUT_W-1:0] first_joint_angle;
    logic signed [fbik_pkg::ANGLE_OUT_W-1:0] second_joint_angle;
    logic                                   unreachable;
    modport source (output valid, output first_joint_angle, output second_joint_angle,
                    output unreachable, input ready);
    modport sink   (input valid, input first_joint_angle, input second_joint_angle,
                    input unreachable, output ready);
endinterface

interface fbik_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [fbik_pkg::CFG_IDX_W-1:0]    index;
    logic [fbik_pkg::CFG_DATA_W-1:0]   data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ src/fbik_front.sv @@
// Front end: squares, reach test, n/a/b terms, normalization and the a*b product.
// Five register stages. Depends on fbik_pkg.
module fbik_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_vld,
    input  logic signed [fbik_pkg::COORD_W-1:0] i_x,
    input  logic signed [fbik_pkg::COORD_W-1:0] i_y,
    input  logic [fbik_pkg::LEN_W-1:0]          i_l1,
    input  logic [fbik_pkg::LEN_W-1:0]          i_l2,
    output fbik_pkg::t_front                    o_front
);
    localparam int CW = fbik_pkg::COORD_W;
    localparam int LW = fbik_pkg::LEN_W;

    // stage 1: captured request
    logic                 r1_vld;
    logic signed [CW-1:0] r1_x, r1_y;
    logic [LW-1:0]        r1_l1, r1_l2;
    // stage 2: squares
    logic                 r2_vld;
    logic signed [CW-1:0] r2_x, r2_y;
    logic [fbik_pkg::SQ_W-1:0]  r2_ax2, r2_ay2, r2_sumsq;
    logic [fbik_pkg::LSQ_W-1:0] r2_l1sq, r2_l2sq, r2_difsq;
    // stage 3: reach test and terms
    logic                 r3_vld, r3_unr;
    logic signed [CW-1:0] r3_x, r3_y;
    logic signed [fbik_pkg::NAB_W-1:0] r3_n, r3_a, r3_b;
    // stage 4: normalized
    logic                 r4_vld, r4_unr;
    logic signed [CW-1:0] r4_x, r4_y;
    logic signed [fbik_pkg::NAB_W-1:0] r4_n;
    logic [fbik_pkg::NORM_W-1:0] r4_a, r4_b;
    // stage 5: product
    fbik_pkg::t_front     r5;

    logic [CW-1:0]  ax, ay, lsum;
    logic [LW-1:0]  ldif;
    logic [fbik_pkg::D2_W-1:0]  d2;
    logic [fbik_pkg::SQ_W-1:0]  n_ax2, n_ay2, n_sumsq;
    logic [fbik_pkg::LSQ_W-1:0] n_l1sq, n_l2sq, n_difsq;
    logic signed [fbik_pkg::NAB_W-1:0] n_n, n_a, n_b, nneg, n_ns;
    logic n_unr;
    logic [fbik_pkg::D2_W-1:0] na, ua, ub, orall;
    logic [1:0] sh;
    logic [fbik_pkg::D2_W-1:0] as_full, bs_full, ns_full;
    logic [fbik_pkg::PROD_W-1:0] n_prod;

    always_comb begin
        ax      = (r1_x < 0) ? CW'(-r1_x) : CW'(r1_x);
        ay      = (r1_y < 0) ? CW'(-r1_y) : CW'(r1_y);
        lsum    = {1'b0, r1_l1} + {1'b0, r1_l2};
        ldif    = (r1_l1 >= r1_l2) ? (r1_l1 - r1_l2) : (r1_l2 - r1_l1);
        n_ax2   = ax * ax;
        n_ay2   = ay * ay;
        n_sumsq = lsum * lsum;
        n_l1sq  = r1_l1 * r1_l1;
        n_l2sq  = r1_l2 * r1_l2;
        n_difsq = ldif * ldif;
    end

    always_comb begin
        d2    = {1'b0, r2_ax2} + {1'b0, r2_ay2};
        n_unr = (d2 == '0) || (d2 > {1'b0, r2_sumsq}) || (d2 < {3'b0, r2_difsq});
        n_n   = $signed({1'b0, d2}) + $signed({4'b0, r2_l1sq}) - $signed({4'b0, r2_l2sq});
        n_a   = $signed({2'b0, r2_sumsq}) - $signed({1'b0, d2});
        n_b   = $signed({1'b0, d2}) - $signed({4'b0, r2_difsq});
    end

    // smallest common right shift that brings a, b and |n| below 2^31
    always_comb begin
        nneg    = -r3_n;
        na      = (r3_n < 0) ? nneg[fbik_pkg::D2_W-1:0] : r3_n[fbik_pkg::D2_W-1:0];
        ua      = r3_a[fbik_pkg::D2_W-1:0];
        ub      = r3_b[fbik_pkg::D2_W-1:0];
        orall   = ua | ub | na;
        if (orall[32]) begin
            sh = 2'd2;
        end else if (orall[31]) begin
            sh = 2'd1;
        end else begin
            sh = 2'd0;
        end
        as_full = ua >> sh;
        bs_full = ub >> sh;
        ns_full = na >> sh;
        n_ns    = (r3_n < 0) ? -$signed({1'b0, ns_full}) : $signed({1'b0, ns_full});
    end

    assign n_prod = r4_a * r4_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5.vld <= 1'b0;
        end else if (i_en) begin
            r1_vld    <= i_vld;
            r2_vld    <= r1_vld;
            r3_vld    <= r2_vld;
            r4_vld    <= r3_vld;
            r5.vld    <= r4_vld;
            r1_x      <= i_x;
            r1_y      <= i_y;
            r1_l1     <= i_l1;
            r1_l2     <= i_l2;
            r2_x      <= r1_x;
            r2_y      <= r1_y;
            r2_ax2    <= n_ax2;
            r2_ay2    <= n_ay2;
            r2_sumsq  <= n_sumsq;
            r2_l1sq   <= n_l1sq;
            r2_l2sq   <= n_l2sq;
            r2_difsq  <= n_difsq;
            r3_x      <= r2_x;
            r3_y      <= r2_y;
            r3_unr    <= n_unr;
            r3_n      <= n_n;
            r3_a      <= n_a;
            r3_b      <= n_b;
            r4_x      <= r3_x;
            r4_y      <= r3_y;
            r4_unr    <= r3_unr;
            r4_n      <= n_ns;
            r4_a      <= as_full[fbik_pkg::NORM_W-1:0];
            r4_b      <= bs_full[fbik_pkg::NORM_W-1:0];
            r5.x      <= r4_x;
            r5.y      <= r4_y;
            r5.unr    <= r4_unr;
            r5.n      <= r4_n;
            r5.prod   <= n_prod;
        end
    end

    assign o_front = r5;

endmodule

@@ src/fbik_isqrt.sv @@
// Pipelined floor square root, one result bit per register stage.
// Depends on fbik_pkg.
module fbik_isqrt (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic [fbik_pkg::PROD_W-1:0]        i_val,
    output logic [fbik_pkg::ROOT_W-1:0]        o_root
);
    localparam int N  = fbik_pkg::ISQRT_STEPS;
    localparam int VW = fbik_pkg::PROD_W + 1;

    logic [VW-1:0] r_v   [0:N-1];
    logic [VW-1:0] r_res [0:N-1];
    logic [VW-1:0] n_v   [0:N-1];
    logic [VW-1:0] n_res [0:N-1];

    always_comb begin
        logic [VW-1:0] pv, pr, bitv, t;
        for (int k = 0; k < N; k++) begin
            pv   = (k == 0) ? {1'b0, i_val} : r_v[(k == 0) ? 0 : k - 1];
            pr   = (k == 0) ? '0 : r_res[(k == 0) ? 0 : k - 1];
            bitv = VW'(1) << (2 * (N - 1 - k));
            t    = pr + bitv;
            if (pv >= t) begin
                n_v[k]   = pv - t;
                n_res[k] = (pr >> 1) + bitv;
            end else begin
                n_v[k]   = pv;
                n_res[k] = pr >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < N; k++) begin
                r_v[k]   <= n_v[k];
                r_res[k] <= n_res[k];
            end
        end
    end

    assign o_root = r_res[N-1][fbik_pkg::ROOT_W-1:0];

endmodule

@@ src/fbik_cordic.sv @@
// Pipelined vectoring CORDIC giving atan2(y, x) in Q4.30: one quadrant stage, then one
// register stage per iteration. Depends on fbik_pkg.
module fbik_cordic (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic signed [fbik_pkg::VEC_W-1:0] i_x,
    input  logic signed [fbik_pkg::VEC_W-1:0] i_y,
    output logic signed [fbik_pkg::ANG_W-1:0] o_z
);
    localparam int N = fbik_pkg::CORDIC_STEPS;

    logic signed [fbik_pkg::VEC_W-1:0] r_x [0:N];
    logic signed [fbik_pkg::VEC_W-1:0] r_y [0:N];
    logic signed [fbik_pkg::ANG_W-1:0] r_z [0:N];
    logic signed [fbik_pkg::VEC_W-1:0] n_x [0:N];
    logic signed [fbik_pkg::VEC_W-1:0] n_y [0:N];
    logic signed [fbik_pkg::ANG_W-1:0] n_z [0:N];

    always_comb begin
        logic signed [fbik_pkg::VEC_W-1:0] dx, dy;
        // left half plane: rotate by a quarter turn first
        if (i_x < 0) begin
            if (i_y >= 0) begin
                n_x[0] = i_y;
                n_y[0] = -i_x;
                n_z[0] = fbik_pkg::HALF_PI_Q30;
            end else begin
                n_x[0] = -i_y;
                n_y[0] = i_x;
                n_z[0] = -fbik_pkg::HALF_PI_Q30;
            end
        end else begin
            n_x[0] = i_x;
            n_y[0] = i_y;
            n_z[0] = '0;
        end
        for (int k = 0; k < N; k++) begin
            dx = r_y[k] >>> k;
            dy = r_x[k] >>> k;
            if (r_y[k] > 0) begin
                n_x[k+1] = r_x[k] + dx;
                n_y[k+1] = r_y[k] - dy;
                n_z[k+1] = r_z[k] + fbik_pkg::atan_q30(k);
            end else if (r_y[k] < 0) begin
                n_x[k+1] = r_x[k] - dx;
                n_y[k+1] = r_y[k] + dy;
                n_z[k+1] = r_z[k] - fbik_pkg::atan_q30(k);
            end else begin
                n_x[k+1] = r_x[k];
                n_y[k+1] = r_y[k];
                n_z[k+1] = r_z[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k <= N; k++) begin
                r_x[k] <= n_x[k];
                r_y[k] <= n_y[k];
                r_z[k] <= n_z[k];
            end
        end
    end

    assign o_z = r_z[N];

endmodule

@@ src/five_bar_leg_inverse_kinematics.sv @@
// Five-bar leg inverse kinematics, fully pipelined.
// Stages in order: front end, root/heading, beta CORDIC, output register. Throughput:
// one request per cycle; the whole pipe advances whenever the output register is empty
// or being taken.
// Reset (synchronous, active low) clears all valid bits and loads both links with 8192.
// Depends on fbik_pkg, fbik_if, fbik_front, fbik_isqrt, fbik_cordic.
module five_bar_leg_inverse_kinematics (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fbik_cfg_if.sink   i_cfg,
    fbik_in_if.sink    i_tgt,
    fbik_out_if.source o_res
);
    localparam int DLY  = fbik_pkg::CORDIC_STEPS + 1;  // heading CORDIC == root depth
    localparam int SH   = fbik_pkg::Q_FRAC - fbik_pkg::ANGLE_FRAC;
    localparam int SW   = fbik_pkg::ANG_W + 1;
    localparam int AOW  = fbik_pkg::ANGLE_OUT_W;
    localparam logic signed [SW-1:0] OUT_MAX = SW'((1 << (AOW - 1)) - 1);
    localparam logic signed [SW-1:0] OUT_MIN = -SW'(1 << (AOW - 1));

    // link length registers
    logic [fbik_pkg::LEN_W-1:0] r_l1, r_l2;

    // one global advance: a stalled output freezes every stage, so nothing drops or repeats
    logic en;

    fbik_pkg::t_front front;
    logic [fbik_pkg::ROOT_W-1:0]        root;
    logic signed [fbik_pkg::ANG_W-1:0]  heading, beta;

    // side data riding alongside the root/heading stages, then the beta stages
    fbik_pkg::t_dly_a r_da [0:DLY-1];
    fbik_pkg::t_dly_b r_db [0:DLY-1];

    logic                   r_out_vld;
    logic signed [AOW-1:0]  r_first, r_second;
    logic                   r_unr;

    assign en          = !r_out_vld || o_res.ready;
    assign i_tgt.ready = en;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l1 <= fbik_pkg::LEN_RESET;
            r_l2 <= fbik_pkg::LEN_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                fbik_pkg::REG_UPPER: r_l1 <= i_cfg.data[fbik_pkg::LEN_W-1:0];
                fbik_pkg::REG_LOWER: r_l2 <= i_cfg.data[fbik_pkg::LEN_W-1:0];
                default: ;  // unknown index: dropped
            endcase
        end
    end

    fbik_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (i_tgt.valid),
        .i_x     (i_tgt.target_x),
        .i_y     (i_tgt.target_y),
        .i_l1    (r_l1),
        .i_l2    (r_l2),
        .o_front (front)
    );

    // sqrt(a*b) and atan2(y, x) run side by side, same depth
    fbik_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_val  (front.prod),
        .o_root (root)
    );

    fbik_cordic u_heading (
        .i_clk (i_clk),
        .i_en  (en),
        .i_x   (fbik_pkg::VEC_W'(front.x)),
        .i_y   (fbik_pkg::VEC_W'(front.y)),
        .o_z   (heading)
    );

    // beta = atan2(sqrt(a*b), n)
    fbik_cordic u_beta (
        .i_clk (i_clk),
        .i_en  (en),
        .i_x   (fbik_pkg::VEC_W'(r_da[DLY-1].n)),
        .i_y   ($signed({{(fbik_pkg::VEC_W - fbik_pkg::ROOT_W){1'b0}}, root})),
        .o_z   (beta)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DLY; k++) begin
                r_da[k].vld <= 1'b0;
                r_db[k].vld <= 1'b0;
            end
        end else if (en) begin
            r_da[0].vld     <= front.vld;
            r_db[0].vld     <= r_da[DLY-1].vld;
            r_da[0].unr     <= front.unr;
            r_da[0].n       <= front.n;
            r_db[0].unr     <= r_da[DLY-1].unr;
            r_db[0].heading <= heading;
            for (int k = 1; k < DLY; k++) begin
                r_da[k].vld     <= r_da[k-1].vld;
                r_db[k].vld     <= r_db[k-1].vld;
                r_da[k].unr     <= r_da[k-1].unr;
                r_da[k].n       <= r_da[k-1].n;
                r_db[k].unr     <= r_db[k-1].unr;
                r_db[k].heading <= r_db[k-1].heading;
            end
        end
    end

    // Q4.30 -> Q4.12: round half up, then saturate
    logic signed [SW-1:0] diff, summ, rdiff, rsum;
    logic signed [AOW-1:0] n_first, n_second;

    always_comb begin
        diff  = SW'(r_db[DLY-1].heading) - SW'(beta);
        summ  = SW'(r_db[DLY-1].heading) + SW'(beta);
        rdiff = (diff + SW'(1 << (SH - 1))) >>> SH;
        rsum  = (summ + SW'(1 << (SH - 1))) >>> SH;
        if (rdiff > OUT_MAX) begin
            n_first = AOW'(OUT_MAX);
        end else if (rdiff < OUT_MIN) begin
            n_first = AOW'(OUT_MIN);
        end else begin
            n_first = AOW'(rdiff);
        end
        if (rsum > OUT_MAX) begin
            n_second = AOW'(OUT_MAX);
        end else if (rsum < OUT_MIN) begin
            n_second = AOW'(OUT_MIN);
        end else begin
            n_second = AOW'(rsum);
        end
        // out of reach: both angles forced to zero
        if (r_db[DLY-1].unr) begin
            n_first  = '0;
            n_second = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r_db[DLY-1].vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_first  <= n_first;
            r_second <= n_second;
            r_unr    <= r_db[DLY-1].unr;
        end
    end

    assign o_res.valid              = r_out_vld;
    assign o_res.first_joint_angle  = r_first;
    assign o_res.second_joint_angle = r_second;
    assign o_res.unreachable        = r_unr;

    a_unr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.unreachable) |->
            (o_res.first_joint_angle == '0 && o_res.second_joint_angle == '0))
        else $error("unreachable result with nonzero angle");

    a_cfg_upper: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg.valid && i_cfg.ready && i_cfg.index == fbik_pkg::REG_UPPER) |=>
            (r_l1 == $past(i_cfg.data[fbik_pkg::LEN_W-1:0])))
        else $error("upper link write not taken");

    a_stall_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.ready) |=> ($stable(r_db[DLY-1].vld) && $stable(beta)))
        else $error("pipeline moved during output stall");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res.valid)
        else $error("result valid right after reset");

endmodule
